>>> rtl/core/double_ended_queue_assert.svh
// assertion macros for the deque core
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// property that holds at every edge out of reset
`define DEQ_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// property that must hold in the cycle after a trigger
`define DEQ_ASSERT_NEXT(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error(msg);

`endif

>>> rtl/core/deq_pkg.sv
package deq_pkg;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_REAR  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_REAR   = 3'd3,
      CMD_DUMP       = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_UNDERFLOW = 2'd1,
      STATUS_OVERFLOW  = 2'd2,
      STATUS_EMPTY     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_SHIFT_R,
      OP_PUSH_R,
      OP_SHIFT_L,
      OP_POP_R,
      OP_ROTATE
   } cell_op_type;

   typedef enum logic {
      STATE_IDLE,
      STATE_DUMP
   } state_type;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned FILL_W  = 6;

endpackage

>>> rtl/core/deq_cell.sv
module deq_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  deq_pkg::cell_op_type          op,
   input  logic [deq_pkg::VALUE_W-1:0]   push_value,
   input  logic [deq_pkg::VALUE_W-1:0]   left_value,
   input  logic                          left_valid,
   input  logic [deq_pkg::VALUE_W-1:0]   right_value,
   input  logic                          right_valid,
   input  logic [deq_pkg::VALUE_W-1:0]   wrap_value,
   output logic [deq_pkg::VALUE_W-1:0]   value,
   output logic                          valid,
   output logic [deq_pkg::VALUE_W-1:0]   tail_value
);
   import deq_pkg::*;

   logic [VALUE_W-1:0] value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               is_tail;

   assign is_tail = valid_ff && !right_valid;

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      case (op)
         OP_SHIFT_R: begin
            value_in = left_value;
            valid_in = left_valid;
         end
         OP_PUSH_R: begin
            if (left_valid && !valid_ff) begin
               value_in = push_value;
               valid_in = 1'b1;
            end
         end
         OP_SHIFT_L: begin
            value_in = right_value;
            valid_in = right_valid;
         end
         OP_POP_R: begin
            if (is_tail) begin
               valid_in = 1'b0;
            end
         end
         OP_ROTATE: begin
            if (is_tail) begin
               value_in = wrap_value;
            end else if (valid_ff) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value      = value_ff;
   assign valid      = valid_ff;
   assign tail_value = is_tail ? value_ff : '0;

endmodule

>>> rtl/core/double_ended_queue.sv
// channel  dir  tdata                         tuser         tlast
// req      in   push_value[31:0]              cmd[2:0]      -
// rsp      out  data_out[31:0], fill[37:32]   status[1:0]   last result of command
//
// push and pop each give one rsp item, one item per cycle while rsp is drained and no dump runs
// a dump of n held values gives n items, req_tready low meanwhile
// each value sits in one cell of a row; front push/pop and dump rotation shift it
// reset is synchronous and empties the queue, no clearing pass
// a stalled rsp holds its item and stalls req and any dump in progress
module double_ended_queue #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // push_value[31:0]
   input  logic [2:0]  req_tuser,   // cmd[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // data_out[31:0], fill_level[37:32], zero[39:38]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);
   import deq_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CUR_W = $clog2(CAPACITY);

   logic [VALUE_W-1:0] cell_value [CAPACITY];
   logic [VALUE_W-1:0] cell_tail  [CAPACITY];
   logic [CAPACITY-1:0] cell_valid;
   cell_op_type        cell_op;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CUR_W-1:0]   cursor_ff, cursor_in;

   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_data_ff, rsp_data_in;
   logic [FILL_W-1:0]  rsp_fill_ff;
   status_type         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               can_load, req_fire, load;
   logic               full, empty, dump_end;
   logic [VALUE_W-1:0] rear_value;
   logic [VALUE_W-1:0] push_value;
   cmd_type            cmd;

   assign push_value = req_tdata[VALUE_W-1:0];
   assign cmd        = cmd_type'(req_tuser);
   assign can_load   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == STATE_IDLE) && can_load;
   assign req_fire   = req_tvalid && req_tready;
   assign full       = count_ff == CNT_W'(CAPACITY);
   assign empty      = count_ff == '0;
   assign dump_end   = (CNT_W'(cursor_ff) + CNT_W'(1)) == count_ff;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [VALUE_W-1:0] left_value, right_value;
      logic               left_valid, right_valid;
      if (i == 0) begin : g_first
         assign left_value = push_value;
         assign left_valid = 1'b1;
      end else begin : g_mid
         assign left_value = cell_value[i-1];
         assign left_valid = cell_valid[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
         assign right_valid = 1'b0;
      end else begin : g_body
         assign right_value = cell_value[i+1];
         assign right_valid = cell_valid[i+1];
      end
      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (cell_op),
         .push_value  (push_value),
         .left_value  (left_value),
         .left_valid  (left_valid),
         .right_value (right_value),
         .right_valid (right_valid),
         .wrap_value  (cell_value[0]),
         .value       (cell_value[i]),
         .valid       (cell_valid[i]),
         .tail_value  (cell_tail[i])
      );
   end

   always_comb begin
      rear_value = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rear_value = rear_value | cell_tail[i];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_fire && cmd == CMD_DUMP && count_ff > CNT_W'(1)) begin
               state_in = STATE_DUMP;
            end
         end
         STATE_DUMP: begin
            if (can_load && dump_end) begin
               state_in = STATE_IDLE;
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   // datapath control
   always_comb begin
      cell_op       = OP_HOLD;
      load          = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_data_in   = '0;
      rsp_last_in   = 1'b1;
      count_in      = count_ff;
      cursor_in     = cursor_ff;
      case (state_ff)
         STATE_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
                     load = 1'b1;
                     if (full) begin
                        rsp_status_in = STATUS_OVERFLOW;
                     end else begin
                        cell_op  = (cmd == CMD_PUSH_FRONT) ? OP_SHIFT_R : OP_PUSH_R;
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_REAR: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_status_in = STATUS_UNDERFLOW;
                     end else begin
                        cell_op     = (cmd == CMD_POP_FRONT) ? OP_SHIFT_L : OP_POP_R;
                        rsp_data_in = (cmd == CMD_POP_FRONT) ? cell_value[0] : rear_value;
                        count_in    = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     load = 1'b1;
                     if (empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        cell_op     = OP_ROTATE;
                        rsp_data_in = cell_value[0];
                        rsp_last_in = count_ff == CNT_W'(1);
                        cursor_in   = (count_ff == CNT_W'(1)) ? '0 : CUR_W'(1);
                     end
                  end
                  default: begin
                     load = 1'b0;
                  end
               endcase
            end
         end
         STATE_DUMP: begin
            if (can_load) begin
               load        = 1'b1;
               cell_op     = OP_ROTATE;
               rsp_data_in = cell_value[0];
               rsp_last_in = dump_end;
               cursor_in   = dump_end ? '0 : cursor_ff + CUR_W'(1);
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         cursor_ff <= cursor_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_fill_ff   <= FILL_W'(count_in);
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_fill_ff, rsp_data_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

`include "double_ended_queue_assert.svh"

   `DEQ_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(CAPACITY), "count above capacity")
   `DEQ_ASSERT_ALWAYS(a_count_cells, $countones(cell_valid) == int'(count_ff),
      "cells and count disagree")
   `DEQ_ASSERT_ALWAYS(a_valid_packed, ((cell_valid + CAPACITY'(1)) & cell_valid) == '0,
      "hole in cell row")
   `DEQ_ASSERT_ALWAYS(a_dump_blocks, !(state_ff == STATE_DUMP && req_tready),
      "item taken during dump")
   `DEQ_ASSERT_NEXT(a_dump_last, state_ff == STATE_DUMP && state_in == STATE_IDLE,
      rsp_tvalid && rsp_tlast, "dump ended without last")

endmodule

>>> verif/double_ended_queue_tb.sv
`timescale 1ns / 100ps

module double_ended_queue_tb;
   import deq_pkg::*;

   localparam int unsigned CAPACITY = 32;
   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * CAPACITY + 8;

   typedef struct packed {
      status_type        status;
      logic [31:0]       data;
      logic [FILL_W-1:0] fill;
      logic              last;
   } deq_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = CMD_PUSH_FRONT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [31:0] held_values[$];
   deq_result_type expected_results[$];
   deq_result_type oldest_result;
   int failures = 0;
   int commands_sent = 0;
   int stall_cycles = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   double_ended_queue #(.CAPACITY(CAPACITY)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic void add_result(input status_type status, input logic [31:0] data,
                                      input int fill, input logic last);
      deq_result_type r;
      r.status = status;
      r.data   = data;
      r.fill   = fill[FILL_W-1:0];
      r.last   = last;
      expected_results.push_back(r);
   endfunction

   function automatic void predict_command(input logic [2:0] cmd, input logic [31:0] value);
      logic [31:0] popped;
      int count;
      count = held_values.size();
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
            if (count >= CAPACITY) begin
               add_result(STATUS_OVERFLOW, '0, count, 1'b1);
            end else begin
               if (cmd == CMD_PUSH_FRONT) held_values.push_front(value);
               else held_values.push_back(value);
               add_result(STATUS_OK, '0, held_values.size(), 1'b1);
            end
         end
         CMD_POP_FRONT, CMD_POP_REAR: begin
            if (count == 0) begin
               add_result(STATUS_UNDERFLOW, '0, 0, 1'b1);
            end else begin
               if (cmd == CMD_POP_FRONT) popped = held_values.pop_front();
               else popped = held_values.pop_back();
               add_result(STATUS_OK, popped, held_values.size(), 1'b1);
            end
         end
         CMD_DUMP: begin
            if (count == 0) begin
               add_result(STATUS_EMPTY, '0, 0, 1'b1);
            end else begin
               for (int i = 0; i < count; i++)
                  add_result(STATUS_OK, held_values[i], count, i == count - 1);
            end
         end
         default: ;
      endcase
   endfunction

   // prediction runs before the check so a same-edge result still finds its entry
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_cycles = 0;
         else stall_cycles++;
         if (req_tvalid && req_tready) predict_command(req_tuser, req_tdata[31:0]);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result item: status %0d data_out %h fill_level %0d last %0d",
                      rsp_tuser, rsp_tdata[31:0], rsp_tdata[37:32], rsp_tlast);
               failures++;
            end else begin
               oldest_result = expected_results.pop_front();
               if (rsp_tuser !== oldest_result.status) begin
                  $error("status: expected %0d, actual %0d", oldest_result.status, rsp_tuser);
                  failures++;
               end
               if (rsp_tdata[31:0] !== oldest_result.data) begin
                  $error("data_out: expected %h, actual %h", oldest_result.data,
                         rsp_tdata[31:0]);
                  failures++;
               end
               if (rsp_tdata[37:32] !== oldest_result.fill) begin
                  $error("fill_level: expected %0d, actual %0d", oldest_result.fill,
                         rsp_tdata[37:32]);
                  failures++;
               end
               if (rsp_tlast !== oldest_result.last) begin
                  $error("last: expected %0d, actual %0d", oldest_result.last, rsp_tlast);
                  failures++;
               end
            end
         end
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic send_command(input logic [2:0] cmd, input logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cmd <= CMD_DUMP) commands_sent++;
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(7))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_push_pop_extremes();
      send_command(CMD_PUSH_FRONT, 32'h8000_0000);
      send_command(CMD_PUSH_REAR,  32'h7fff_ffff);
      send_command(CMD_PUSH_FRONT, 32'h0000_0000);
      send_command(CMD_PUSH_REAR,  32'hffff_ffff);
      send_command(CMD_PUSH_FRONT, 32'h5555_5555);
      send_command(CMD_PUSH_REAR,  32'haaaa_aaaa);
      send_command(CMD_DUMP,       32'h0000_0000);
      send_command(CMD_POP_FRONT,  32'h0000_0000);
      send_command(CMD_POP_REAR,   32'h0000_0000);
      send_command(CMD_POP_FRONT,  32'h0000_0000);
      send_command(CMD_POP_REAR,   32'h0000_0000);
      send_command(CMD_POP_FRONT,  32'h0000_0000);
      send_command(CMD_POP_REAR,   32'h0000_0000);
   endtask

   task automatic test_empty_queue();
      send_command(CMD_POP_FRONT, 32'hffff_ffff);
      send_command(CMD_POP_REAR,  32'hffff_ffff);
      send_command(CMD_DUMP,      32'hffff_ffff);
   endtask

   task automatic test_unused_codes();
      for (int code = CMD_UNUSED_FIRST; code <= CMD_UNUSED_LAST; code++)
         send_command(3'(code), 32'hffff_ffff);
      send_command(CMD_PUSH_REAR, 32'h0000_0001);
      send_command(CMD_DUMP,      32'h0000_0000);
      send_command(CMD_POP_FRONT, 32'h0000_0000);
   endtask

   task automatic test_random_traffic(input int item_count);
      int first_count;
      int run_len;
      int pick;
      first_count = commands_sent;
      // fill past capacity so overflow and a full dump show up in every phase
      repeat (CAPACITY + 2)
         send_command(3'($urandom_range(CMD_PUSH_REAR, CMD_PUSH_FRONT)), random_value());
      send_command(CMD_DUMP, random_value());
      while (commands_sent - first_count < item_count) begin
         pick = $urandom_range(99);
         run_len = $urandom_range(CAPACITY + 4, 1);
         if (pick < 25) begin
            repeat (run_len)
               send_command(3'($urandom_range(CMD_PUSH_REAR, CMD_PUSH_FRONT)),
                            random_value());
         end else if (pick < 45) begin
            repeat (run_len)
               send_command(3'($urandom_range(CMD_POP_REAR, CMD_POP_FRONT)),
                            random_value());
         end else if (pick < 55) begin
            send_command(CMD_DUMP, random_value());
         end else begin
            repeat (run_len) begin
               if ($urandom_range(99) < 6)
                  send_command(3'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                               random_value());
               else
                  send_command(3'($urandom_range(CMD_DUMP, CMD_PUSH_FRONT)),
                               random_value());
            end
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_idle_pct = 38;
      recv_idle_pct = 64;
      test_push_pop_extremes();
      test_empty_queue();
      test_unused_codes();
      test_random_traffic(135);

      send_idle_pct = 64;
      recv_idle_pct = 38;
      test_random_traffic(135);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(135);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
